[hw/rtl/hysteresis_direction_detector_core_assert.svh]
// assertion macros for the hysteresis direction detector
// expects signals named clk and rst_n in the scope of each use
`ifndef HYSTERESIS_DIRECTION_DETECTOR_CORE_ASSERT_SVH
`define HYSTERESIS_DIRECTION_DETECTOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define HDD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hdd assertion failed");
`define HDD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("hdd forbidden condition seen");
`else
`define HDD_ASSERT(lbl, prop)
`define HDD_ASSERT_NEVER(lbl, cond)
`endif

`endif

[hw/rtl/hdd_pkg.sv]
// shared types, codes and transition tables of the hysteresis direction detector
// no dependencies
package hdd_pkg;

  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int THR_W            = 15;
  localparam int EV_W             = 2;
  localparam int ST_W             = 4;
  localparam int DIR_W            = 2;

  localparam logic [THR_W-1:0] THR_RESET = 15'd100;

  // level classification
  localparam logic [EV_W-1:0] EV_UP   = 2'd0;
  localparam logic [EV_W-1:0] EV_MID  = 2'd1;
  localparam logic [EV_W-1:0] EV_DOWN = 2'd2;

  // history states, named previous level -> current level
  localparam logic [ST_W-1:0] ST_UNDEF_UP  = 4'd0;
  localparam logic [ST_W-1:0] ST_MID_UP    = 4'd1;
  localparam logic [ST_W-1:0] ST_DOWN_UP   = 4'd2;
  localparam logic [ST_W-1:0] ST_UNDEF_MID = 4'd3;
  localparam logic [ST_W-1:0] ST_UP_MID    = 4'd4;
  localparam logic [ST_W-1:0] ST_DOWN_MID  = 4'd5;
  localparam logic [ST_W-1:0] ST_UNDEF_DN  = 4'd6;
  localparam logic [ST_W-1:0] ST_UP_DN     = 4'd7;
  localparam logic [ST_W-1:0] ST_MID_DN    = 4'd8;
  localparam logic [ST_W-1:0] ST_UNDEF     = 4'd9;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_UP   = 2'd1;
  localparam logic [1:0] ACT_DOWN = 2'd2;

  localparam logic signed [DIR_W-1:0] DIR_UP   = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_DOWN = 2'sb11;
  localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;

  typedef logic [EV_W-1:0] event_t;
  typedef logic [ST_W-1:0] hstate_t;

  function automatic hstate_t next_state(input event_t ev, input hstate_t st);
    hstate_t ns;
    ns = ST_UNDEF;
    case (ev)
      EV_UP: begin
        case (st)
          ST_UNDEF_UP, ST_MID_UP, ST_DOWN_UP:    ns = st;
          ST_UNDEF_MID, ST_UP_MID, ST_DOWN_MID:  ns = ST_MID_UP;
          ST_UNDEF_DN, ST_UP_DN, ST_MID_DN:      ns = ST_DOWN_UP;
          default:                               ns = ST_UNDEF_UP;
        endcase
      end
      EV_MID: begin
        case (st)
          ST_UNDEF_UP, ST_MID_UP, ST_DOWN_UP:    ns = ST_UP_MID;
          ST_UNDEF_MID, ST_UP_MID, ST_DOWN_MID:  ns = st;
          ST_UNDEF_DN, ST_UP_DN, ST_MID_DN:      ns = ST_DOWN_MID;
          default:                               ns = ST_UNDEF_MID;
        endcase
      end
      EV_DOWN: begin
        case (st)
          ST_UNDEF_UP, ST_MID_UP, ST_DOWN_UP:    ns = ST_UP_DN;
          ST_UNDEF_MID, ST_UP_MID, ST_DOWN_MID:  ns = ST_MID_DN;
          ST_UNDEF_DN, ST_UP_DN, ST_MID_DN:      ns = st;
          default:                               ns = ST_UNDEF_DN;
        endcase
      end
      default: ns = ST_UNDEF;
    endcase
    return ns;
  endfunction

  // action depends on the event and the state before the transition
  function automatic logic [1:0] action_of(input event_t ev, input hstate_t st);
    logic [1:0] act;
    act = ACT_NONE;
    case (ev)
      EV_UP: begin
        case (st)
          ST_DOWN_MID, ST_UNDEF_DN, ST_UP_DN, ST_MID_DN: act = ACT_UP;
          default:                                       act = ACT_NONE;
        endcase
      end
      EV_DOWN: begin
        case (st)
          ST_UNDEF_UP, ST_MID_UP, ST_DOWN_UP, ST_UP_MID: act = ACT_DOWN;
          default:                                       act = ACT_NONE;
        endcase
      end
      default: act = ACT_NONE;
    endcase
    return act;
  endfunction

endpackage

[hw/rtl/hdd_if.sv]
// valid/ready channel interfaces for sample and result transactions
// depends on hdd_pkg
interface hdd_in_if #(
  parameter int SAMPLE_WIDTH = hdd_pkg::DEF_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] rssi_diff;

  modport source (output valid, output rssi_diff, input ready);
  modport sink   (input valid, input rssi_diff, output ready);
endinterface

interface hdd_out_if;
  logic                                    valid;
  logic                                    ready;
  logic        [hdd_pkg::EV_W-1:0]         level_event;
  logic        [hdd_pkg::ST_W-1:0]         history_state;
  logic signed [hdd_pkg::DIR_W-1:0]        direction;
  logic                                    crossed_ever;
  logic                                    crossed_now;

  modport source (output valid, output level_event, output history_state,
                  output direction, output crossed_ever, output crossed_now,
                  input ready);
  modport sink   (input valid, input level_event, input history_state,
                  input direction, input crossed_ever, input crossed_now,
                  output ready);
endinterface

[hw/rtl/hysteresis_direction_detector_core.sv]
// hysteresis direction detector: schmitt classification with level history
// depends on hdd_pkg, hdd_if.sv and hysteresis_direction_detector_core_assert.svh
//
//  channel | dir | payload                                   | handshake
//  in_if   | in  | rssi_diff                                 | valid/ready
//  out_if  | out | level_event history_state direction       | valid/ready
//          |     | crossed_ever crossed_now                  |
//  cfg     | in  | cfg_wdata (threshold)                     | cfg_we, no wait
//
// one sample per cycle sustained while out_if.ready holds; each sample passes
// the sample register, then classification and lookup into the result register
// synchronous active-low reset clears valids, history (undefined), direction, flags
// and sets threshold to its default
// a stalled result holds both stages; the sample register still fills while empty
`include "hysteresis_direction_detector_core_assert.svh"

module hysteresis_direction_detector_core #(
  parameter int SAMPLE_WIDTH = hdd_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  hdd_in_if.sink                     in_if,
  hdd_out_if.source                  out_if,
  input  logic                       cfg_we,
  input  logic [hdd_pkg::THR_W-1:0]  cfg_wdata
);
  import hdd_pkg::*;

  localparam int CMP_W = ((SAMPLE_WIDTH > THR_W) ? SAMPLE_WIDTH : THR_W) + 2;

  logic [THR_W-1:0]               threshold_r;

  // sample stage
  logic                           s0_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] s0_sample_r;

  // history state
  hstate_t                        hist_r;
  logic signed [DIR_W-1:0]        dir_r;
  logic                           seen_r;

  // result stage
  logic                           out_valid_r;
  event_t                         out_ev_r;
  hstate_t                        out_st_r;
  logic signed [DIR_W-1:0]        out_dir_r;
  logic                           out_seen_r;
  logic                           out_now_r;

  logic                           advance;
  logic signed [CMP_W-1:0]        x_ext;
  logic signed [CMP_W-1:0]        t_pos;
  logic signed [CMP_W-1:0]        t_neg;
  event_t                         ev;
  logic [1:0]                     act;
  hstate_t                        hist_nxt;
  logic signed [DIR_W-1:0]        dir_nxt;
  logic                           seen_nxt;
  logic                           now_nxt;

  assign advance     = !out_valid_r || out_if.ready;
  assign in_if.ready = !s0_valid_r || advance;

  always_comb begin
    x_ext = {{(CMP_W-SAMPLE_WIDTH){s0_sample_r[SAMPLE_WIDTH-1]}}, s0_sample_r};
    t_pos = {{(CMP_W-THR_W){1'b0}}, threshold_r};
    t_neg = -t_pos;
    if (x_ext > t_pos) begin
      ev = EV_UP;
    end else if (x_ext < t_neg) begin
      ev = EV_DOWN;
    end else begin
      ev = EV_MID;
    end
    act      = action_of(ev, hist_r);
    hist_nxt = next_state(ev, hist_r);
    dir_nxt  = dir_r;
    seen_nxt = seen_r;
    now_nxt  = 1'b0;
    case (act)
      ACT_UP: begin
        dir_nxt  = DIR_UP;
        seen_nxt = 1'b1;
        now_nxt  = 1'b1;
      end
      ACT_DOWN: begin
        dir_nxt  = DIR_DOWN;
        seen_nxt = 1'b1;
        now_nxt  = 1'b1;
      end
      default: begin
        dir_nxt  = dir_r;
        seen_nxt = seen_r;
        now_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THR_RESET;
    end else if (cfg_we) begin
      threshold_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s0_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s0_sample_r <= in_if.rssi_diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hist_r      <= ST_UNDEF;
      dir_r       <= DIR_NONE;
      seen_r      <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s0_valid_r;
      if (s0_valid_r) begin
        hist_r <= hist_nxt;
        dir_r  <= dir_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s0_valid_r) begin
      out_ev_r   <= ev;
      out_st_r   <= hist_nxt;
      out_dir_r  <= dir_nxt;
      out_seen_r <= seen_nxt;
      out_now_r  <= now_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.level_event   = out_ev_r;
  assign out_if.history_state = out_st_r;
  assign out_if.direction     = out_dir_r;
  assign out_if.crossed_ever  = out_seen_r;
  assign out_if.crossed_now   = out_now_r;

  // crossing flag is sticky and agrees with a known direction
  `HDD_ASSERT(a_seen_sticky, seen_r |=> seen_r)
  `HDD_ASSERT(a_dir_matches_seen, (dir_r != DIR_NONE) == seen_r)
  `HDD_ASSERT_NEVER(a_hist_range, hist_r > ST_UNDEF)
  `HDD_ASSERT(a_now_implies_ever, (out_valid_r && out_now_r) |-> out_seen_r)
  `HDD_ASSERT(a_hist_follows_result,
              (advance && s0_valid_r) |=> (hist_r == out_st_r))

endmodule

[tb/hysteresis_direction_detector_core_test.sv]
// self-checking test of the hysteresis direction detector core: a directed table, then
// random batches at several thresholds, checked against a behavioural predictor
// depends on hdd_pkg, hdd_if.sv and hysteresis_direction_detector_core.sv
module hysteresis_direction_detector_core_test;
  import hdd_pkg::*;

  typedef logic signed [DEF_SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    event_t                   ev;
    hstate_t                  st;
    logic signed [DIR_W-1:0]  dir;
    logic                     cross_ever;
    logic                     cross_now;
  } det_result_t;

  typedef struct {
    bit          is_cfg;
    int          value;
    bit          typed;
    det_result_t want;
  } plan_row_t;

  // rows indexed by event code (up, mid, down), columns by history state
  localparam hstate_t step_table [3][10] = '{
    '{ST_UNDEF_UP, ST_MID_UP, ST_DOWN_UP, ST_MID_UP, ST_MID_UP,
      ST_MID_UP, ST_DOWN_UP, ST_DOWN_UP, ST_DOWN_UP, ST_UNDEF_UP},
    '{ST_UP_MID, ST_UP_MID, ST_UP_MID, ST_UNDEF_MID, ST_UP_MID,
      ST_DOWN_MID, ST_DOWN_MID, ST_DOWN_MID, ST_DOWN_MID, ST_UNDEF_MID},
    '{ST_UP_DN, ST_UP_DN, ST_UP_DN, ST_MID_DN, ST_MID_DN,
      ST_MID_DN, ST_UNDEF_DN, ST_UP_DN, ST_MID_DN, ST_UNDEF_DN}
  };

  // action is taken from the state before the transition
  localparam logic [1:0] act_table [3][10] = '{
    '{ACT_NONE, ACT_NONE, ACT_NONE, ACT_NONE, ACT_NONE,
      ACT_UP, ACT_UP, ACT_UP, ACT_UP, ACT_NONE},
    '{ACT_NONE, ACT_NONE, ACT_NONE, ACT_NONE, ACT_NONE,
      ACT_NONE, ACT_NONE, ACT_NONE, ACT_NONE, ACT_NONE},
    '{ACT_DOWN, ACT_DOWN, ACT_DOWN, ACT_NONE, ACT_DOWN,
      ACT_NONE, ACT_NONE, ACT_NONE, ACT_NONE, ACT_NONE}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [THR_W-1:0] cfg_wdata = '0;

  hdd_in_if #(.SAMPLE_WIDTH(DEF_SAMPLE_WIDTH)) in_if ();
  hdd_out_if out_if ();

  hysteresis_direction_detector_core #(.SAMPLE_WIDTH(DEF_SAMPLE_WIDTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state, mirrors the block
  int                      thr_now = int'(THR_RESET);
  hstate_t                 hist_state = ST_UNDEF;
  logic signed [DIR_W-1:0] dir_seen = DIR_NONE;
  logic                    cross_seen = 1'b0;

  det_result_t pending_results[$];
  plan_row_t   plan[$];
  int          err_count = 0;
  int          results_seen = 0;
  bit          quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic det_result_t predict_sample(sample_t x);
    det_result_t r;
    event_t      ev;
    logic [1:0]  act;
    int          xv;
    xv = x;
    if (xv > thr_now) ev = EV_UP;
    else if (xv < -thr_now) ev = EV_DOWN;
    else ev = EV_MID;
    act = act_table[ev][hist_state];
    r.cross_now = 1'b0;
    if (act == ACT_UP) begin
      dir_seen = DIR_UP;
      cross_seen = 1'b1;
      r.cross_now = 1'b1;
    end else if (act == ACT_DOWN) begin
      dir_seen = DIR_DOWN;
      cross_seen = 1'b1;
      r.cross_now = 1'b1;
    end
    hist_state = step_table[ev][hist_state];
    r.ev = ev;
    r.st = hist_state;
    r.dir = dir_seen;
    r.cross_ever = cross_seen;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic sample_t draw_sample(int thr);
    int v;
    case ($urandom_range(0, 9))
      0, 1:    v = int'($urandom_range(0, 65535)) - 32768;
      2, 3, 4: v = (thr < 32767) ? int'($urandom_range(thr + 1, 32767)) : thr;
      5, 6:    v = int'($urandom_range(0, 2 * thr)) - thr;
      7, 8:    v = -int'($urandom_range(thr + 1, 32768));
      default: begin
        // right on a border or one step past it
        case ($urandom_range(0, 3))
          0:       v = thr;
          1:       v = -thr;
          2:       v = (thr < 32767) ? thr + 1 : thr;
          default: v = -thr - 1;
        endcase
      end
    endcase
    return sample_t'(v);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    if (err_count <= 50)
      $display("mismatch at result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
  endtask

  task automatic add_step(bit is_cfg, int value, bit typed, det_result_t want);
    plan_row_t row;
    row.is_cfg = is_cfg;
    row.value = value;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endtask

  task automatic send_sample(sample_t x, bit typed, det_result_t want);
    det_result_t pred;
    int gap;
    in_if.valid <= 1'b1;
    in_if.rssi_diff <= x;
    do @(posedge clk); while (!in_if.ready);
    pred = predict_sample(x);
    pending_results.push_back(typed ? want : pred);
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // threshold only changes once the pipeline has drained
  task automatic write_threshold(int v);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= THR_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_now = v;
  endtask

  initial begin : result_check
    det_result_t want;
    int          stall_left;
    int          hold_left;
    bit          held;
    stall_left = 0;
    hold_left = 0;
    held = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected transaction, level_event", out_if.level_event, -1);
        end else begin
          want = pending_results.pop_front();
          if (out_if.level_event !== want.ev)
            report_mismatch("level_event", out_if.level_event, want.ev);
          if (out_if.history_state !== want.st)
            report_mismatch("history_state", out_if.history_state, want.st);
          if (out_if.direction !== want.dir)
            report_mismatch("direction", out_if.direction, want.dir);
          if (out_if.crossed_ever !== want.cross_ever)
            report_mismatch("crossed_ever", out_if.crossed_ever, want.cross_ever);
          if (out_if.crossed_now !== want.cross_now)
            report_mismatch("crossed_now", out_if.crossed_now, want.cross_now);
        end
      end
      // one long back-pressure stretch so the block fills and stalls its input
      if (!held && results_seen >= 300) begin
        held = 1'b1;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int first_pick;
    int thr;
    in_if.valid = 1'b0;
    in_if.rssi_diff = '0;

    // leaving the undefined state: up, mid or down, chosen per run
    case ($urandom_range(0, 2))
      0:       first_pick = 32767;
      1:       first_pick = 0;
      default: first_pick = -32768;
    endcase
    add_step(0, first_pick, 0, '0);
    add_step(0, 32767, 0, '0);
    add_step(0, 100, 0, '0);
    add_step(0, -101, 1, '{EV_DOWN, ST_MID_DN, DIR_DOWN, 1'b1, 1'b1});
    add_step(0, -32768, 1, '{EV_DOWN, ST_MID_DN, DIR_DOWN, 1'b1, 1'b0});
    add_step(0, -100, 1, '{EV_MID, ST_DOWN_MID, DIR_DOWN, 1'b1, 1'b0});
    add_step(0, 101, 1, '{EV_UP, ST_MID_UP, DIR_UP, 1'b1, 1'b1});
    add_step(0, -32768, 1, '{EV_DOWN, ST_UP_DN, DIR_DOWN, 1'b1, 1'b1});
    add_step(0, 32767, 1, '{EV_UP, ST_DOWN_UP, DIR_UP, 1'b1, 1'b1});
    add_step(0, -101, 1, '{EV_DOWN, ST_UP_DN, DIR_DOWN, 1'b1, 1'b1});
    add_step(0, 0, 1, '{EV_MID, ST_DOWN_MID, DIR_DOWN, 1'b1, 1'b0});
    // zero threshold: any non-zero sample is up or down
    add_step(1, 0, 0, '0);
    add_step(0, 0, 1, '{EV_MID, ST_DOWN_MID, DIR_DOWN, 1'b1, 1'b0});
    add_step(0, 1, 1, '{EV_UP, ST_MID_UP, DIR_UP, 1'b1, 1'b1});
    add_step(0, 0, 1, '{EV_MID, ST_UP_MID, DIR_UP, 1'b1, 1'b0});
    add_step(0, -1, 1, '{EV_DOWN, ST_MID_DN, DIR_DOWN, 1'b1, 1'b1});
    // widest threshold: only the most negative sample is down
    add_step(1, 32767, 0, '0);
    add_step(0, 32767, 1, '{EV_MID, ST_DOWN_MID, DIR_DOWN, 1'b1, 1'b0});
    add_step(0, -32767, 1, '{EV_MID, ST_DOWN_MID, DIR_DOWN, 1'b1, 1'b0});
    add_step(0, -32768, 1, '{EV_DOWN, ST_MID_DN, DIR_DOWN, 1'b1, 1'b0});
    add_step(1, 100, 0, '0);
    add_step(0, 101, 1, '{EV_UP, ST_DOWN_UP, DIR_UP, 1'b1, 1'b1});
    add_step(0, -1, 1, '{EV_MID, ST_UP_MID, DIR_UP, 1'b1, 1'b0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_threshold(plan[i].value);
      else send_sample(sample_t'(plan[i].value), plan[i].typed, plan[i].want);
    end

    for (int b = 0; b < 10; b++) begin
      case (b)
        0:       thr = 0;
        1:       thr = 32767;
        2:       thr = 1;
        3:       thr = 32766;
        default: thr = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 400)
                                                  : $urandom_range(0, 32767);
      endcase
      quiet = (b % 4 == 2);
      write_threshold(thr);
      repeat (85) send_sample(draw_sample(thr), 1'b0, '0);
    end

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
